// ----- design/framed_line_packet_receiver_defines.svh -----
// Assertion macros for the framed line packet receiver.
// Used by modules that have clk_i and rst_ni in scope; no other dependencies.
`ifndef FRAMED_LINE_PACKET_RECEIVER_DEFINES_SVH
`define FRAMED_LINE_PACKET_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FLPR_AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FLPR_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/flpr_pkg.sv -----
// Shared types and constants of the framed line packet receiver.
// No dependencies; imported by the interfaces and every module.
`timescale 1ns / 1ps

package flpr_pkg;

  localparam int MaxPayload = 63;
  localparam int AddrW      = $clog2(MaxPayload);
  localparam int LenW       = $clog2(MaxPayload + 1);
  localparam int CapW       = 7;
  localparam int CmpW       = (CapW > LenW) ? CapW : LenW;
  localparam int ReqW       = 2;
  localparam int ByteW      = 8;
  localparam int TimeW      = 32;
  localparam int PaddrW     = 3;
  localparam int PdataW     = 32;

  localparam logic [ByteW-1:0]  HeaderReset = 8'h40;
  localparam logic [ByteW-1:0]  ChCr        = 8'h0D;
  localparam logic [ByteW-1:0]  ChLf        = 8'h0A;
  localparam logic [PaddrW-1:0] AddrHeader  = 3'd0;

  typedef enum logic [ReqW-1:0] {
    REQ_RX       = 2'd0,
    REQ_TAKE     = 2'd1,
    REQ_MBOX_RST = 2'd2
  } req_e;

  // controller -> datapath
  typedef struct packed {
    logic rx_en;
    logic mbox_clear;
    logic take_refuse;
    logic take_start;
    logic fetch_adv;
    logic out_load;
    logic out_empty;
    logic out_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic refuse;
    logic at_end;
    logic idx_zero;
    logic out_busy;
    logic out_fire;
  } sts_t;

endpackage

// ----- design/flpr_in_if.sv -----
// Input channel of the packet receiver: valid/ready plus request payload.
// Depends on flpr_pkg.
`timescale 1ns / 1ps

interface flpr_in_if;
  import flpr_pkg::*;

  logic             valid;
  logic             ready;
  logic [ReqW-1:0]  req_type;
  logic [ByteW-1:0] rx_byte;
  logic [TimeW-1:0] now_ms;
  logic [CapW-1:0]  take_capacity;

  modport source (output valid, req_type, rx_byte, now_ms, take_capacity, input ready);
  modport sink   (input valid, req_type, rx_byte, now_ms, take_capacity, output ready);
endinterface

// ----- design/flpr_out_if.sv -----
// Result channel of the packet receiver: valid/ready plus one result beat.
// Depends on flpr_pkg.
`timescale 1ns / 1ps

interface flpr_out_if;
  import flpr_pkg::*;

  logic             valid;
  logic             ready;
  logic             packet_taken;
  logic [ByteW-1:0] data_byte;
  logic             byte_valid;
  logic             last;
  logic [TimeW-1:0] packet_time;
  logic [TimeW-1:0] max_gap;
  logic [TimeW-1:0] overwrite_count;

  modport source (output valid, packet_taken, data_byte, byte_valid, last, packet_time,
                  max_gap, overwrite_count, input ready);
  modport sink   (input valid, packet_taken, data_byte, byte_valid, last, packet_time,
                  max_gap, overwrite_count, output ready);
endinterface

// ----- design/flpr_ctrl.sv -----
// Request sequencer: accepts requests and steps a take through the mailbox.
// Depends on flpr_pkg and framed_line_packet_receiver_defines.svh.
`timescale 1ns / 1ps
`include "framed_line_packet_receiver_defines.svh"

module flpr_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [flpr_pkg::ReqW-1:0]   in_req_i,
  output logic                        in_ready_o,
  input  flpr_pkg::sts_t              sts_i,
  output flpr_pkg::cmd_t              cmd_o
);
  import flpr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EMIT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   in_ready;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    in_ready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        // a pending result only blocks takes
        in_ready = !sts_i.out_busy || (in_req_i != REQ_TAKE);
        if (in_valid_i && in_ready) begin
          unique case (in_req_i)
            REQ_RX:       cmd_o.rx_en      = 1'b1;
            REQ_MBOX_RST: cmd_o.mbox_clear = 1'b1;
            REQ_TAKE: begin
              if (sts_i.refuse) begin
                cmd_o.take_refuse = 1'b1;
              end else begin
                cmd_o.take_start = 1'b1;
                state_d          = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        if (sts_i.idx_zero) begin
          if (sts_i.at_end) begin
            cmd_o.out_load  = 1'b1;
            cmd_o.out_empty = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.fetch_adv = 1'b1;
          end
        end else begin
          // emit the held byte; last when the byte just read ends the packet
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = sts_i.at_end;
          if (sts_i.at_end) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.fetch_adv = 1'b1;
            state_d         = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_fire) begin
          state_d = S_FETCH;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `FLPR_AST_SAME(a_load_free, cmd_o.out_load || cmd_o.take_refuse, !sts_i.out_busy, "result loaded over a pending beat")
  `FLPR_AST_NEXT(a_start_fetch, cmd_o.take_start, (state_q == S_FETCH) && sts_i.idx_zero, "take did not start at index zero")
  `FLPR_AST_NEXT(a_last_idle, cmd_o.out_load && (cmd_o.out_empty || cmd_o.out_last), state_q == S_IDLE, "final beat did not end the take")
  `FLPR_AST_SAME(a_emit_busy, state_q == S_EMIT, sts_i.out_busy, "waiting for a beat that is not pending")

endmodule

// ----- design/flpr_datapath.sv -----
// Framing, ping-pong payload banks, mailbox state and the result register.
// Depends on flpr_pkg, flpr_out_if.
`timescale 1ns / 1ps

module flpr_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [flpr_pkg::ByteW-1:0]   header_i,
  input  logic [flpr_pkg::ByteW-1:0]   rx_byte_i,
  input  logic [flpr_pkg::TimeW-1:0]   now_ms_i,
  input  logic [flpr_pkg::CapW-1:0]    take_capacity_i,
  input  flpr_pkg::cmd_t               cmd_i,
  output flpr_pkg::sts_t               sts_o,
  flpr_out_if.source                   out_m
);
  import flpr_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE    = 3'b001,
    F_PAYLOAD = 3'b010,
    F_CR      = 3'b100
  } frame_e;

  // framing and mailbox state
  frame_e           fstate_q, fstate_d;
  logic [LenW-1:0]  blen_q, blen_d;
  logic             ovf_q, ovf_d;
  logic             build_sel_q, build_sel_d;   // bank being built; mailbox is the other
  logic [LenW-1:0]  mlen_q, mlen_d;
  logic             mfull_q, mfull_d;
  logic [TimeW-1:0] mtime_q, mtime_d;
  logic [TimeW-1:0] prev_q, prev_d;
  logic             has_prev_q, has_prev_d;
  logic [TimeW-1:0] pgap_q, pgap_d;
  logic [TimeW-1:0] ow_q, ow_d;

  logic             wr_en;
  logic             publish;
  logic [TimeW-1:0] gap_w;

  // take state
  logic [LenW-1:0]  limit_q, limit_w;
  logic [LenW-1:0]  idx_q, idx_d;
  logic [ByteW-1:0] hold_q;
  logic [TimeW-1:0] tgap_q;
  logic [CmpW-1:0]  cap_m1;
  logic [CmpW-1:0]  len_ext;

  // payload banks
  logic [ByteW-1:0] bank0_mem [MaxPayload];
  logic [ByteW-1:0] bank1_mem [MaxPayload];
  logic [ByteW-1:0] rd0_q, rd1_q, rdata;
  logic             rd_en;

  // result register
  logic             out_valid_q;
  logic             o_taken_q, o_bvalid_q, o_last_q;
  logic [ByteW-1:0] o_data_q;
  logic [TimeW-1:0] o_time_q, o_gap_q, o_ow_q;

  assign gap_w = now_ms_i - prev_q;

  always_comb begin
    fstate_d    = fstate_q;
    blen_d      = blen_q;
    ovf_d       = ovf_q;
    build_sel_d = build_sel_q;
    mlen_d      = mlen_q;
    mfull_d     = mfull_q;
    mtime_d     = mtime_q;
    prev_d      = prev_q;
    has_prev_d  = has_prev_q;
    pgap_d      = pgap_q;
    ow_d        = ow_q;
    wr_en       = 1'b0;
    publish     = 1'b0;

    if (cmd_i.rx_en) begin
      if (rx_byte_i == header_i) begin
        fstate_d = F_PAYLOAD;
        blen_d   = '0;
        ovf_d    = 1'b0;
      end else begin
        unique case (fstate_q)
          F_PAYLOAD: begin
            priority if (rx_byte_i == ChCr) begin
              fstate_d = F_CR;
            end else if (rx_byte_i == ChLf) begin
              fstate_d = F_IDLE;
              blen_d   = '0;
              ovf_d    = 1'b0;
            end else if (blen_q < LenW'(MaxPayload)) begin
              wr_en  = 1'b1;
              blen_d = blen_q + LenW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          F_CR: begin
            publish  = (rx_byte_i == ChLf) && !ovf_q;
            fstate_d = F_IDLE;
            blen_d   = '0;
            ovf_d    = 1'b0;
          end
          default: ;  // idle: bytes other than the header are dropped
        endcase
      end
    end

    if (publish) begin
      if (mfull_q) begin
        ow_d = ow_q + TimeW'(1);
      end
      build_sel_d = ~build_sel_q;
      mlen_d      = blen_q;
      if (has_prev_q) begin
        if (gap_w > pgap_q) begin
          pgap_d = gap_w;
        end
      end else begin
        has_prev_d = 1'b1;
      end
      prev_d  = now_ms_i;
      mtime_d = now_ms_i;
      mfull_d = 1'b1;
    end

    if (cmd_i.mbox_clear) begin
      mfull_d    = 1'b0;
      mlen_d     = '0;
      mtime_d    = now_ms_i;
      ow_d       = '0;
      pgap_d     = '0;
      has_prev_d = 1'b0;
      prev_d     = now_ms_i;
      fstate_d   = F_IDLE;
      blen_d     = '0;
      ovf_d      = 1'b0;
    end

    if (cmd_i.take_start) begin
      mfull_d = 1'b0;
      pgap_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fstate_q    <= F_IDLE;
      blen_q      <= '0;
      ovf_q       <= 1'b0;
      build_sel_q <= 1'b0;
      mlen_q      <= '0;
      mfull_q     <= 1'b0;
      mtime_q     <= '0;
      prev_q      <= '0;
      has_prev_q  <= 1'b0;
      pgap_q      <= '0;
      ow_q        <= '0;
    end else begin
      fstate_q    <= fstate_d;
      blen_q      <= blen_d;
      ovf_q       <= ovf_d;
      build_sel_q <= build_sel_d;
      mlen_q      <= mlen_d;
      mfull_q     <= mfull_d;
      mtime_q     <= mtime_d;
      prev_q      <= prev_d;
      has_prev_q  <= has_prev_d;
      pgap_q      <= pgap_d;
      ow_q        <= ow_d;
    end
  end

  // take length: min(capacity - 1, mailbox length)
  assign cap_m1  = CmpW'(take_capacity_i) - CmpW'(1);
  assign len_ext = CmpW'(mlen_q);
  assign limit_w = (cap_m1 > len_ext) ? mlen_q : LenW'(cap_m1);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.take_start) begin
      idx_d = '0;
    end else if (cmd_i.fetch_adv) begin
      idx_d = idx_q + LenW'(1);
    end
  end

  // prefetch the byte at the new index so the current one knows if it is last
  assign rd_en = (cmd_i.take_start || cmd_i.fetch_adv) && (idx_d < LenW'(MaxPayload));

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_start) begin
      limit_q <= limit_w;
      tgap_q  <= pgap_q;
    end
    if (cmd_i.take_start || cmd_i.fetch_adv) begin
      idx_q <= idx_d;
    end
    if (cmd_i.fetch_adv) begin
      hold_q <= rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && !build_sel_q) begin
      bank0_mem[blen_q[AddrW-1:0]] <= rx_byte_i;
    end
    if (rd_en) begin
      rd0_q <= bank0_mem[idx_d[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && build_sel_q) begin
      bank1_mem[blen_q[AddrW-1:0]] <= rx_byte_i;
    end
    if (rd_en) begin
      rd1_q <= bank1_mem[idx_d[AddrW-1:0]];
    end
  end

  assign rdata = build_sel_q ? rd0_q : rd1_q;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.take_refuse || cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_refuse) begin
      o_taken_q  <= 1'b0;
      o_data_q   <= '0;
      o_bvalid_q <= 1'b0;
      o_last_q   <= 1'b1;
      o_time_q   <= '0;
      o_gap_q    <= '0;
      o_ow_q     <= ow_q;
    end else if (cmd_i.out_load) begin
      o_taken_q  <= 1'b1;
      o_data_q   <= cmd_i.out_empty ? '0 : hold_q;
      o_bvalid_q <= !cmd_i.out_empty;
      o_last_q   <= cmd_i.out_empty || cmd_i.out_last;
      o_time_q   <= mtime_q;
      o_gap_q    <= tgap_q;
      o_ow_q     <= ow_q;
    end
  end

  assign out_m.valid           = out_valid_q;
  assign out_m.packet_taken    = o_taken_q;
  assign out_m.data_byte       = o_data_q;
  assign out_m.byte_valid      = o_bvalid_q;
  assign out_m.last            = o_last_q;
  assign out_m.packet_time     = o_time_q;
  assign out_m.max_gap         = o_gap_q;
  assign out_m.overwrite_count = o_ow_q;

  assign sts_o.refuse   = (take_capacity_i == '0) || !mfull_q;
  assign sts_o.at_end   = (idx_q >= limit_q) ? 1'b1 : (rdata == '0);
  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.out_busy = out_valid_q;
  assign sts_o.out_fire = out_valid_q && out_m.ready;

endmodule

// ----- design/framed_line_packet_receiver.sv -----
// Top level of the framed line packet receiver: APB register, sequencer, datapath.
// Depends on flpr_pkg, flpr_in_if, flpr_out_if, flpr_ctrl, flpr_datapath.
//
//   channel  | dir | handshake              | beat
//   ---------+-----+------------------------+---------------------------------------
//   in_s     | in  | valid / ready          | req_type, rx_byte, now_ms, take_capacity
//   out_m    | out | valid / ready          | one result of a take
//   apb      | in  | psel, penable, pready  | header_byte at byte address 0
//
// Takes: a refused take gives one beat, as does an empty one (no byte).
//   A granted take holds the input until its final beat is loaded: the
//   registered bank read plus one lookahead byte find the final beat.
// Reset: rst_ni is asynchronous, active low; payload banks are not cleared.
// Stalls: a pending result beat blocks only new takes; bytes and mailbox
//   resets are still accepted. During a take no input beat is accepted.
`timescale 1ns / 1ps

module framed_line_packet_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  flpr_in_if.sink                       in_s,
  flpr_out_if.source                    out_m,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [flpr_pkg::PaddrW-1:0]   paddr,
  input  logic [flpr_pkg::PdataW-1:0]   pwdata,
  output logic [flpr_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);
  import flpr_pkg::*;

  logic [ByteW-1:0] header_q;
  logic             cfg_wr;
  cmd_t             cmd;
  sts_t             sts;

  // APB register file: just the header byte, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == AddrHeader);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
    end else if (cfg_wr) begin
      header_q <= pwdata[ByteW-1:0];
    end
  end

  assign prdata = (paddr == AddrHeader) ? PdataW'(header_q) : '0;

  // sequencer decides; datapath holds all framing and mailbox state
  flpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_s.valid),
    .in_req_i   (in_s.req_type),
    .in_ready_o (in_s.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  flpr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .header_i        (header_q),
    .rx_byte_i       (in_s.rx_byte),
    .now_ms_i        (in_s.now_ms),
    .take_capacity_i (in_s.take_capacity),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_m           (out_m)
  );

endmodule
